FILE: hw/rtl/esel_pkg.sv
// esel_pkg: widths, register map, reset values and the control program of
// the encoder speed estimator. No dependencies.
`default_nettype none

package esel_pkg;

   localparam int TICK_W        = 32;
   localparam int THETA_W       = 32;
   localparam int OMEGA_W       = 30;
   localparam int RPM_W         = 22;
   localparam int RATE_W        = 16;
   localparam int STEP_W        = 14;
   localparam int ALPHA_W       = 15;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_INDEX_LSB = 2;
   localparam int MUL_A_W       = 30;
   localparam int MUL_B_W       = 17;
   localparam int PROD_W        = MUL_A_W + MUL_B_W;
   localparam int ACC_W         = PROD_W + 1;
   localparam int FILT_SHIFT    = 15;

   localparam logic [RATE_W-1:0]  RATE_RESET     = 16'd1000;
   localparam logic [STEP_W-1:0]  MAX_STEP_RESET = 14'd1024;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 15'd29491;

   localparam logic signed [MUL_B_W-1:0] ALPHA_ONE = 17'sd32768;
   localparam logic signed [MUL_B_W-1:0] RPM_SCALE = 17'sd60;
   localparam logic signed [ACC_W-1:0]   ROUND_HALF = 48'sd16384;

   localparam logic signed [ACC_W-1:0] OMEGA_MAX = 48'sd536870911;
   localparam logic signed [ACC_W-1:0] OMEGA_MIN = -48'sd536870912;
   localparam logic signed [ACC_W-1:0] RPM_MAX   = 48'sd2097151;
   localparam logic signed [ACC_W-1:0] RPM_MIN   = -48'sd2097152;

   typedef enum logic [1:0] {
      REG_SAMPLE_RATE = 2'd0,
      REG_MAX_STEP    = 2'd1,
      REG_ALPHA       = 2'd2
   } reg_index_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_CHECK   = 3'd0;
   localparam step_type STEP_UNWRAP  = 3'd1;
   localparam step_type STEP_RAW_MUL = 3'd2;
   localparam step_type STEP_OLD_MUL = 3'd3;
   localparam step_type STEP_NEW_MUL = 3'd4;
   localparam step_type STEP_FILTER  = 3'd5;
   localparam step_type STEP_RPM_MUL = 3'd6;
   localparam step_type STEP_FINISH  = 3'd7;

   typedef enum logic [1:0] {
      A_DELTA = 2'd0,
      A_OMEGA = 2'd1,
      A_RAW   = 2'd2
   } a_sel_type;

   typedef enum logic [1:0] {
      B_RATE  = 2'd0,
      B_ALPHA = 2'd1,
      B_BETA  = 2'd2,
      B_SIXTY = 2'd3
   } b_sel_type;

   typedef enum logic [1:0] {
      COND_NONE     = 2'd0,
      COND_OLD      = 2'd1,
      COND_NO_SPEED = 2'd2
   } cond_type;

   typedef struct packed {
      logic      mul_en;
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      do_check;
      logic      do_unwrap;
      logic      do_raw;
      logic      do_acc;
      logic      do_filter;
      logic      do_finish;
      cond_type  cond;
      step_type  target;
   } ctrl_type;

   // control program, one word per step
   function automatic ctrl_type ctrl_rom(input step_type step);
      ctrl_type w;
      w = ctrl_type'('0);
      case (step)
         STEP_CHECK: begin
            w.do_check = 1'b1;
            w.cond     = COND_OLD;
            w.target   = STEP_RPM_MUL;
         end
         STEP_UNWRAP: begin
            w.do_unwrap = 1'b1;
            w.cond      = COND_NO_SPEED;
            w.target    = STEP_RPM_MUL;
         end
         STEP_RAW_MUL: begin
            w.mul_en = 1'b1;
            w.a_sel  = A_DELTA;
            w.b_sel  = B_RATE;
         end
         STEP_OLD_MUL: begin
            w.mul_en = 1'b1;
            w.a_sel  = A_OMEGA;
            w.b_sel  = B_ALPHA;
            w.do_raw = 1'b1;
         end
         STEP_NEW_MUL: begin
            w.mul_en = 1'b1;
            w.a_sel  = A_RAW;
            w.b_sel  = B_BETA;
            w.do_acc = 1'b1;
         end
         STEP_FILTER: begin
            w.do_filter = 1'b1;
         end
         STEP_RPM_MUL: begin
            w.mul_en = 1'b1;
            w.a_sel  = A_OMEGA;
            w.b_sel  = B_SIXTY;
         end
         STEP_FINISH: begin
            w.do_finish = 1'b1;
         end
         default: begin
            w = ctrl_type'('0);
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/esel_if.sv
// esel channel interfaces: sample request beat and speed result beat.
// Depends on esel_pkg for field widths.
`default_nettype none

interface esel_req_if #(
   parameter int ANGLE_BITS = 14
);
   logic                          valid;
   logic                          ready;
   logic [esel_pkg::TICK_W-1:0]   sample_tick;
   logic [ANGLE_BITS-1:0]         angle;

   modport source (output valid, sample_tick, angle, input ready);
   modport sink   (input valid, sample_tick, angle, output ready);
endinterface

interface esel_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [esel_pkg::THETA_W-1:0] angle_total;
   logic signed [esel_pkg::OMEGA_W-1:0] omega;
   logic signed [esel_pkg::RPM_W-1:0]   speed_rpm;
   logic                                was_new;
   logic                                glitch;

   modport source (output valid, angle_total, omega, speed_rpm, was_new, glitch,
                   input ready);
   modport sink   (input valid, angle_total, omega, speed_rpm, was_new, glitch,
                   output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/encoder_speed_estimator_lpf_top.sv
// encoder_speed_estimator_lpf_top: angle unwrap, speed from angle step and
// first-order low-pass, run by a small control program. Uses esel_pkg, esel_if.
//
// One request beat carries a sample tick and an angle; one result beat comes
// back for each. A new tick with a good step walks all 8 steps of the control
// program; a repeated tick jumps from the check step and the first sample after
// reset or a glitch from the unwrap step, ahead to the rpm scaling step. The
// single shared 30x17 multiplier is used in turn for step*rate, the two filter
// products and the rpm scaling. The next request is taken the cycle after the
// result is loaded, while that result still waits.
// Registers: 0x0 sample_rate_hz, 0x4 max_step, 0x8 alpha_q15; write only while idle.
`default_nettype none

module encoder_speed_estimator_lpf_top #(
   parameter int ANGLE_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   esel_req_if.sink                            req,
   esel_rsp_if.source                          rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [esel_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [esel_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [esel_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int DELTA_W = ANGLE_BITS + 1;
   localparam int WIDE_W  = ANGLE_BITS + 2;
   localparam int CMP_W   = (DELTA_W > esel_pkg::STEP_W) ? DELTA_W : esel_pkg::STEP_W;
   localparam logic signed [WIDE_W-1:0] HALF_TURN = WIDE_W'(2 ** (ANGLE_BITS - 1));
   localparam logic signed [WIDE_W-1:0] FULL_TURN = WIDE_W'(2 ** ANGLE_BITS);

   function automatic logic signed [esel_pkg::OMEGA_W-1:0] sat_omega(
      input logic signed [esel_pkg::ACC_W-1:0] v);
      logic signed [esel_pkg::ACC_W-1:0] c;
      c = v;
      if (v > esel_pkg::OMEGA_MAX) c = esel_pkg::OMEGA_MAX;
      if (v < esel_pkg::OMEGA_MIN) c = esel_pkg::OMEGA_MIN;
      return c[esel_pkg::OMEGA_W-1:0];
   endfunction

   function automatic logic signed [esel_pkg::RPM_W-1:0] sat_rpm(
      input logic signed [esel_pkg::ACC_W-1:0] v);
      logic signed [esel_pkg::ACC_W-1:0] c;
      c = v;
      if (v > esel_pkg::RPM_MAX) c = esel_pkg::RPM_MAX;
      if (v < esel_pkg::RPM_MIN) c = esel_pkg::RPM_MIN;
      return c[esel_pkg::RPM_W-1:0];
   endfunction

   // configuration
   logic [esel_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [esel_pkg::STEP_W-1:0]  max_step_ff, max_step_in;
   logic [esel_pkg::ALPHA_W-1:0] alpha_ff, alpha_in;

   // sequencer
   logic                busy_ff, busy_in;
   esel_pkg::step_type  pc_ff, pc_in;
   esel_pkg::ctrl_type  ctrl;

   // estimator state
   logic [esel_pkg::TICK_W-1:0]          last_tick_ff, last_tick_in;
   logic                                 unwrap_ready_ff, unwrap_ready_in;
   logic [ANGLE_BITS-1:0]                prev_angle_ff, prev_angle_in;
   logic [esel_pkg::THETA_W-1:0]         theta_ff, theta_in;
   logic signed [esel_pkg::OMEGA_W-1:0]  omega_ff, omega_in;

   // working registers
   logic [esel_pkg::TICK_W-1:0]          tick_ff, tick_in;
   logic [ANGLE_BITS-1:0]                angle_ff, angle_in;
   logic signed [DELTA_W-1:0]            delta_ff, delta_in;
   logic signed [esel_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [esel_pkg::OMEGA_W-1:0]  raw_ff, raw_in;
   logic signed [esel_pkg::PROD_W-1:0]   acc_ff, acc_in;
   logic                                 was_new_ff, was_new_in;
   logic                                 glitch_ff, glitch_in;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [esel_pkg::THETA_W-1:0]         rsp_theta_ff, rsp_theta_in;
   logic signed [esel_pkg::OMEGA_W-1:0]  rsp_omega_ff, rsp_omega_in;
   logic signed [esel_pkg::RPM_W-1:0]    rsp_rpm_ff, rsp_rpm_in;
   logic                                 rsp_new_ff, rsp_new_in;
   logic                                 rsp_glitch_ff, rsp_glitch_in;

   // datapath
   logic                                 accept;
   logic                                 csr_write;
   esel_pkg::reg_index_type              csr_index;
   logic                                 is_new;
   logic signed [WIDE_W-1:0]             delta_diff;
   logic signed [WIDE_W-1:0]             delta_wrap;
   logic signed [DELTA_W-1:0]            delta_now;
   logic [DELTA_W-1:0]                   delta_mag;
   logic                                 over_limit;
   logic                                 no_speed;
   logic                                 step_go;
   logic                                 take_jump;
   logic signed [esel_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [esel_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [esel_pkg::PROD_W-1:0]   prod_now;
   logic signed [esel_pkg::ACC_W-1:0]    filt_sum;
   logic signed [esel_pkg::ACC_W-1:0]    filt_shift;
   logic signed [esel_pkg::ACC_W-1:0]    rpm_shift;

   assign ctrl       = esel_pkg::ctrl_rom(pc_ff);
   assign accept     = req.valid && req.ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = esel_pkg::reg_index_type'(
                          csr_paddr[esel_pkg::CSR_ADDR_W-1:esel_pkg::CSR_INDEX_LSB]);

   assign req.ready       = !busy_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.angle_total = rsp_theta_ff;
   assign rsp.omega       = rsp_omega_ff;
   assign rsp.speed_rpm   = rsp_rpm_ff;
   assign rsp.was_new     = rsp_new_ff;
   assign rsp.glitch      = rsp_glitch_ff;

   always_comb begin
      case (csr_index)
         esel_pkg::REG_SAMPLE_RATE: csr_prdata = esel_pkg::CSR_DATA_W'(rate_ff);
         esel_pkg::REG_MAX_STEP:    csr_prdata = esel_pkg::CSR_DATA_W'(max_step_ff);
         esel_pkg::REG_ALPHA:       csr_prdata = esel_pkg::CSR_DATA_W'(alpha_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // step wrapped to a half turn
   always_comb begin
      is_new     = tick_ff != last_tick_ff;
      delta_diff = $signed({2'b00, angle_ff}) - $signed({2'b00, prev_angle_ff});
      if (delta_diff > HALF_TURN) begin
         delta_wrap = delta_diff - FULL_TURN;
      end else if (delta_diff < -HALF_TURN) begin
         delta_wrap = delta_diff + FULL_TURN;
      end else begin
         delta_wrap = delta_diff;
      end
      delta_now  = delta_wrap[DELTA_W-1:0];
      delta_mag  = (delta_now < 0) ? DELTA_W'(-delta_now) : DELTA_W'(delta_now);
      over_limit = CMP_W'(delta_mag) > CMP_W'(max_step_ff);
      no_speed   = !unwrap_ready_ff || over_limit;
   end

   // shared multiplier
   always_comb begin
      case (ctrl.a_sel)
         esel_pkg::A_DELTA: mul_a = esel_pkg::MUL_A_W'(delta_ff);
         esel_pkg::A_OMEGA: mul_a = omega_ff;
         esel_pkg::A_RAW:   mul_a = raw_ff;
         default:           mul_a = '0;
      endcase
      case (ctrl.b_sel)
         esel_pkg::B_RATE:  mul_b = $signed({1'b0, rate_ff});
         esel_pkg::B_ALPHA: mul_b = $signed({2'b00, alpha_ff});
         esel_pkg::B_BETA:  mul_b = esel_pkg::ALPHA_ONE - $signed({2'b00, alpha_ff});
         esel_pkg::B_SIXTY: mul_b = esel_pkg::RPM_SCALE;
         default:           mul_b = '0;
      endcase
      prod_now = esel_pkg::PROD_W'(mul_a) * esel_pkg::PROD_W'(mul_b);
   end

   assign filt_sum   = esel_pkg::ACC_W'(acc_ff) + esel_pkg::ACC_W'(prod_ff)
                       + esel_pkg::ROUND_HALF;
   assign filt_shift = filt_sum >>> esel_pkg::FILT_SHIFT;
   assign rpm_shift  = esel_pkg::ACC_W'(prod_ff) >>> ANGLE_BITS;

   assign step_go   = busy_ff && (!ctrl.do_finish || !rsp_valid_ff || rsp.ready);
   assign take_jump = ((ctrl.cond == esel_pkg::COND_OLD) && !is_new)
                   || ((ctrl.cond == esel_pkg::COND_NO_SPEED) && no_speed);

   always_comb begin
      rate_in         = rate_ff;
      max_step_in     = max_step_ff;
      alpha_in        = alpha_ff;
      busy_in         = busy_ff;
      pc_in           = pc_ff;
      last_tick_in    = last_tick_ff;
      unwrap_ready_in = unwrap_ready_ff;
      prev_angle_in   = prev_angle_ff;
      theta_in        = theta_ff;
      omega_in        = omega_ff;
      tick_in         = tick_ff;
      angle_in        = angle_ff;
      delta_in        = delta_ff;
      prod_in         = prod_ff;
      raw_in          = raw_ff;
      acc_in          = acc_ff;
      was_new_in      = was_new_ff;
      glitch_in       = glitch_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_theta_in    = rsp_theta_ff;
      rsp_omega_in    = rsp_omega_ff;
      rsp_rpm_in      = rsp_rpm_ff;
      rsp_new_in      = rsp_new_ff;
      rsp_glitch_in   = rsp_glitch_ff;

      if (csr_write) begin
         case (csr_index)
            esel_pkg::REG_SAMPLE_RATE: rate_in     = csr_pwdata[esel_pkg::RATE_W-1:0];
            esel_pkg::REG_MAX_STEP:    max_step_in = csr_pwdata[esel_pkg::STEP_W-1:0];
            esel_pkg::REG_ALPHA:       alpha_in    = csr_pwdata[esel_pkg::ALPHA_W-1:0];
            default: begin
            end
         endcase
      end

      if (accept) begin
         busy_in  = 1'b1;
         pc_in    = esel_pkg::STEP_CHECK;
         tick_in  = req.sample_tick;
         angle_in = req.angle;
      end else if (step_go) begin
         if (ctrl.do_finish) begin
            busy_in = 1'b0;
            pc_in   = esel_pkg::STEP_CHECK;
         end else if (take_jump) begin
            pc_in = ctrl.target;
         end else begin
            pc_in = pc_ff + 3'd1;
         end

         if (ctrl.mul_en) begin
            prod_in = prod_now;
         end
         if (ctrl.do_check) begin
            was_new_in = is_new;
            glitch_in  = 1'b0;
            if (is_new) begin
               last_tick_in = tick_ff;
            end
         end
         if (ctrl.do_unwrap) begin
            unwrap_ready_in = 1'b1;
            prev_angle_in   = angle_ff;
            delta_in        = delta_now;
            if (!unwrap_ready_ff) begin
               theta_in = esel_pkg::THETA_W'(angle_ff);
            end else begin
               theta_in  = theta_ff + esel_pkg::THETA_W'(delta_now);
               glitch_in = over_limit;
            end
         end
         if (ctrl.do_raw) begin
            raw_in = sat_omega(esel_pkg::ACC_W'(prod_ff));
         end
         if (ctrl.do_acc) begin
            acc_in = prod_ff;
         end
         if (ctrl.do_filter) begin
            omega_in = sat_omega(filt_shift);
         end
         if (ctrl.do_finish) begin
            rsp_valid_in  = 1'b1;
            rsp_theta_in  = theta_ff;
            rsp_omega_in  = omega_ff;
            rsp_rpm_in    = sat_rpm(rpm_shift);
            rsp_new_in    = was_new_ff;
            rsp_glitch_in = glitch_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff         <= esel_pkg::RATE_RESET;
         max_step_ff     <= esel_pkg::MAX_STEP_RESET;
         alpha_ff        <= esel_pkg::ALPHA_RESET;
         busy_ff         <= 1'b0;
         pc_ff           <= esel_pkg::STEP_CHECK;
         last_tick_ff    <= '0;
         unwrap_ready_ff <= 1'b0;
         prev_angle_ff   <= '0;
         theta_ff        <= '0;
         omega_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rate_ff         <= rate_in;
         max_step_ff     <= max_step_in;
         alpha_ff        <= alpha_in;
         busy_ff         <= busy_in;
         pc_ff           <= pc_in;
         last_tick_ff    <= last_tick_in;
         unwrap_ready_ff <= unwrap_ready_in;
         prev_angle_ff   <= prev_angle_in;
         theta_ff        <= theta_in;
         omega_ff        <= omega_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff       <= tick_in;
      angle_ff      <= angle_in;
      delta_ff      <= delta_in;
      prod_ff       <= prod_in;
      raw_ff        <= raw_in;
      acc_ff        <= acc_in;
      was_new_ff    <= was_new_in;
      glitch_ff     <= glitch_in;
      rsp_theta_ff  <= rsp_theta_in;
      rsp_omega_ff  <= rsp_omega_in;
      rsp_rpm_ff    <= rsp_rpm_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_glitch_ff <= rsp_glitch_in;
   end

   // idle sequencer always sits at the program start
   a_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> pc_ff == esel_pkg::STEP_CHECK)
      else $error("sequencer idle away from program start");

   // an accepted beat starts the program
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && pc_ff == esel_pkg::STEP_CHECK)
      else $error("accepted beat did not start the program");

   // a result is loaded only from the last step
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == esel_pkg::STEP_FINISH)
      else $error("result loaded outside the finish step");

   // skipped filter leaves the speed alone
   a_hold_on_skip: assert property (@(posedge clock) disable iff (reset)
      busy_ff && pc_ff == esel_pkg::STEP_UNWRAP && no_speed |=> $stable(omega_ff))
      else $error("speed changed on glitch or first sample");

   // glitch only on a new sample
   a_glitch_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_glitch_ff && !rsp_new_ff))
      else $error("glitch flagged on a repeated tick");

endmodule

`default_nettype wire

FILE: sim/esel_speed_checker.sv
// esel_speed_checker: watches the request, result and register ports of the
// encoder speed estimator, predicts every result beat and compares it.
// Depends on esel_pkg and the channel interfaces in esel_if.
module esel_speed_checker (
   input  logic                            clock,
   input  logic                            reset,
   esel_req_if                             req,
   esel_rsp_if                             rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [esel_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [esel_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              fail_count,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ANGLE_BITS = 14;
   localparam longint TURN       = 64'sd1 << ANGLE_BITS;
   localparam longint HALF       = 64'sd1 << (ANGLE_BITS - 1);
   localparam longint SPEED_HI   = 64'sd536870911;
   localparam longint SPEED_LO   = -64'sd536870912;
   localparam longint RPM_HI     = 64'sd2097151;
   localparam longint RPM_LO     = -64'sd2097152;

   typedef struct packed {
      logic signed [esel_pkg::THETA_W-1:0] theta;
      logic signed [esel_pkg::OMEGA_W-1:0] omega;
      logic signed [esel_pkg::RPM_W-1:0]   rpm;
      logic                                was_new;
      logic                                glitch;
   } speed_result_type;

   logic [esel_pkg::RATE_W-1:0]         rate_cfg;
   logic [esel_pkg::STEP_W-1:0]         max_step_cfg;
   logic [esel_pkg::ALPHA_W-1:0]        alpha_cfg;
   logic [esel_pkg::TICK_W-1:0]         seen_tick;
   logic                                angle_seeded;
   logic [ANGLE_BITS-1:0]               last_angle;
   logic [esel_pkg::THETA_W-1:0]        theta_sum;
   logic signed [esel_pkg::OMEGA_W-1:0] omega_lpf;
   speed_result_type                    speed_results_due[$];

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic speed_result_type predict_speed(
      input logic [esel_pkg::TICK_W-1:0] tick,
      input logic [ANGLE_BITS-1:0] ang);
      speed_result_type res;
      longint           delta;
      longint           raw;
      longint           acc;
      res = '0;
      if (tick != seen_tick) begin
         res.was_new = 1'b1;
         seen_tick = tick;
         if (!angle_seeded) begin
            angle_seeded = 1'b1;
            last_angle = ang;
            theta_sum = esel_pkg::THETA_W'(ang);
         end else begin
            delta = longint'(ang) - longint'(last_angle);
            if (delta > HALF) delta = delta - TURN;
            else if (delta < -HALF) delta = delta + TURN;
            theta_sum = theta_sum + esel_pkg::THETA_W'(delta);
            last_angle = ang;
            if ((delta < 0 ? -delta : delta) > longint'(max_step_cfg)) begin
               res.glitch = 1'b1;
            end else begin
               raw = clamp(delta * longint'(rate_cfg), SPEED_LO, SPEED_HI);
               acc = longint'(alpha_cfg) * longint'(omega_lpf)
                   + (64'sd32768 - longint'(alpha_cfg)) * raw + 64'sd16384;
               omega_lpf = esel_pkg::OMEGA_W'(clamp(acc >>> 15, SPEED_LO, SPEED_HI));
            end
         end
      end
      res.theta = theta_sum;
      res.omega = omega_lpf;
      res.rpm   = esel_pkg::RPM_W'(clamp((longint'(omega_lpf) * 60) >>> ANGLE_BITS,
                                         RPM_LO, RPM_HI));
      return res;
   endfunction

   task automatic log_failure(input string msg);
      if (fail_count < 10) $display("%0t: %s", $time, msg);
      fail_count = fail_count + 1;
   endtask

   task automatic compare_field(input string field, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (got !== want)
         log_failure($sformatf("%s expected %0d got %0d", field, want, got));
   endtask

   always @(posedge clock) begin
      speed_result_type want;
      if (reset) begin
         rate_cfg     = esel_pkg::RATE_RESET;
         max_step_cfg = esel_pkg::MAX_STEP_RESET;
         alpha_cfg    = esel_pkg::ALPHA_RESET;
         seen_tick    = '0;
         angle_seeded = 1'b0;
         last_angle   = '0;
         theta_sum    = '0;
         omega_lpf    = '0;
         speed_results_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (esel_pkg::reg_index_type'(
                     csr_paddr[esel_pkg::CSR_ADDR_W-1:esel_pkg::CSR_INDEX_LSB]))
               esel_pkg::REG_SAMPLE_RATE: rate_cfg = csr_pwdata[esel_pkg::RATE_W-1:0];
               esel_pkg::REG_MAX_STEP:    max_step_cfg = csr_pwdata[esel_pkg::STEP_W-1:0];
               esel_pkg::REG_ALPHA:       alpha_cfg = csr_pwdata[esel_pkg::ALPHA_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (speed_results_due.size() == 0) begin
               log_failure("result beat with no result expected");
            end else begin
               want = speed_results_due.pop_front();
               compare_field("angle_total", want.theta, rsp.angle_total);
               compare_field("omega", want.omega, rsp.omega);
               compare_field("speed_rpm", want.rpm, rsp.speed_rpm);
               compare_field("was_new", {63'd0, want.was_new}, {63'd0, rsp.was_new});
               compare_field("glitch", {63'd0, want.glitch}, {63'd0, rsp.glitch});
            end
         end
         if (req.valid === 1'b1 && req.ready === 1'b1)
            speed_results_due.push_back(predict_speed(req.sample_tick, req.angle));
      end
      outstanding <= speed_results_due.size();
   end

endmodule

FILE: sim/encoder_speed_estimator_lpf_top_tb.sv
// encoder_speed_estimator_lpf_top_tb: drives sample beats and register writes
// into the speed estimator with random idling and reports the verdict.
// Depends on esel_pkg, esel_if, the block and esel_speed_checker.
module encoder_speed_estimator_lpf_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [esel_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [esel_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [esel_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;
   int                              fail_count;
   int                              outstanding;
   int                              idle_level;
   logic [esel_pkg::TICK_W-1:0]     cur_tick;
   logic [13:0]                     cur_angle;
   logic [esel_pkg::STEP_W-1:0]     max_step_now;

   esel_req_if req_bus ();
   esel_rsp_if rsp_bus ();

   encoder_speed_estimator_lpf_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   esel_speed_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // result side stalls
   initial begin
      forever begin
         if (idle_level == 0) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
            if (idle_level == 1) repeat ($urandom_range(5, 40)) @(posedge clock);
            else repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   task automatic send_beat(input logic [esel_pkg::TICK_W-1:0] tick, input logic [13:0] ang);
      int gap;
      gap = 0;
      if (idle_level != 0 && $urandom_range(0, 99) < (idle_level == 1 ? 15 : 40))
         gap = $urandom_range(1, 17);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample_tick <= tick;
      req_bus.angle       <= ang;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input esel_pkg::reg_index_type idx,
                            input logic [esel_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= esel_pkg::CSR_ADDR_W'(idx) << esel_pkg::CSR_INDEX_LSB;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
   endtask

   task automatic set_speed_config(input logic [esel_pkg::RATE_W-1:0] rate,
                                   input logic [esel_pkg::STEP_W-1:0] max_step,
                                   input logic [esel_pkg::ALPHA_W-1:0] alpha);
      write_reg(esel_pkg::REG_SAMPLE_RATE, esel_pkg::CSR_DATA_W'(rate));
      write_reg(esel_pkg::REG_MAX_STEP, esel_pkg::CSR_DATA_W'(max_step));
      write_reg(esel_pkg::REG_ALPHA, esel_pkg::CSR_DATA_W'(alpha));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      max_step_now = max_step;
   endtask

   // mostly consecutive ticks with steps around the glitch limit
   task automatic send_random_sample();
      int pick;
      int lim;
      int delta;
      lim  = max_step_now > 8192 ? 8192 : int'(max_step_now);
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
         send_beat(cur_tick, 14'($urandom_range(0, 16383)));
      end else begin
         if (pick < 12) cur_tick = $urandom;
         else cur_tick = cur_tick + 1;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            delta = int'($urandom_range(0, 2 * lim)) - lim;
         end else if (pick < 85) begin
            case ($urandom_range(0, 4))
               0: delta = 0;
               1: delta = lim;
               2: delta = -lim;
               3: delta = lim + 1;
               default: delta = -(lim + 1);
            endcase
         end else begin
            delta = $urandom_range(0, 16383);
         end
         cur_angle = cur_angle + 14'(delta);
         send_beat(cur_tick, cur_angle);
      end
   endtask

   initial begin
      idle_level = 0;
      max_step_now = esel_pkg::MAX_STEP_RESET;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.sample_tick <= '0;
      req_bus.angle <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: tick zero repeat, seeding, wrap and glitch edges
      send_beat(32'd0, 14'd100);
      send_beat(32'd1, 14'd16383);
      send_beat(32'd1, 14'd5);
      send_beat(32'd2, 14'd0);
      send_beat(32'd3, 14'd16383);
      send_beat(32'd4, 14'd1023);
      send_beat(32'd5, 14'd2048);
      send_beat(32'd6, 14'd10240);
      send_beat(32'd7, 14'd2048);
      send_beat(32'd8, 14'd10241);
      send_beat(32'hFFFF_FFFF, 14'd10000);
      send_beat(32'd0, 14'd9000);
      drain_results();

      // full rate, half turn steps, filter bypass
      set_speed_config(16'd65535, 14'd8192, 15'd0);
      send_beat(32'd9, 14'd808);
      send_beat(32'd10, 14'd9000);
      send_beat(32'd11, 14'd9000);
      send_beat(32'd11, 14'd0);
      drain_results();

      // zero rate, zero step limit, slowest filter
      set_speed_config(16'd0, 14'd0, 15'd32767);
      send_beat(32'd12, 14'd9000);
      send_beat(32'd13, 14'd9001);
      send_beat(32'd14, 14'd9001);
      send_beat(32'd15, 14'd9002);
      drain_results();

      cur_tick  = 32'd15;
      cur_angle = 14'd9002;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_speed_config(esel_pkg::RATE_RESET, esel_pkg::MAX_STEP_RESET,
                                esel_pkg::ALPHA_RESET);
            1: set_speed_config(16'd65535, 14'd8192, 15'd0);
            2: set_speed_config(16'd1, 14'd0, 15'd32767);
            4: set_speed_config(16'd20000, 14'd300, 15'd16384);
            default: set_speed_config(16'($urandom_range(1, 65535)),
                                      14'($urandom_range(0, 8192)),
                                      15'($urandom_range(0, 32767)));
         endcase
         idle_level = (phase == 2) ? 0 : 1 + (phase % 2);
         for (int n = 0; n < 140; n++) begin
            if (phase == 5 && n == 100) idle_level = 0;
            send_random_sample();
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: encoder_speed_estimator_lpf_top.f
hw/rtl/esel_pkg.sv
hw/rtl/esel_if.sv
hw/rtl/encoder_speed_estimator_lpf_top.sv
sim/esel_speed_checker.sv
sim/encoder_speed_estimator_lpf_top_tb.sv
